[design/bspe_pkg.sv]
// ----------------------------------------------------------------------------
// bspe_pkg
// Shared types and constants for the boolean stack program evaluator.
// ----------------------------------------------------------------------------
package bspe_pkg;

    localparam int BSPE_STACK_DEPTH = 64;
    localparam int BSPE_OP_W        = 3;
    localparam int BSPE_VAR_W       = 4;
    localparam int BSPE_CNT_W       = 8;
    localparam int BSPE_IN_TDATA_W  = 8;
    localparam int BSPE_OUT_TDATA_W = 16;

    typedef enum logic [BSPE_OP_W-1:0] {
        OP_AND   = 3'd0,
        OP_OR    = 3'd1,
        OP_NOT   = 3'd2,
        OP_XOR   = 3'd3,
        OP_PUSH1 = 3'd4,
        OP_PUSH2 = 3'd5,
        OP_PUSH3 = 3'd6,
        OP_PUSH4 = 3'd7
    } t_op;

    typedef struct packed {
        logic                  last;
        logic [BSPE_VAR_W-1:0] variables;
        t_op                   op;
    } t_instr;

    typedef struct packed {
        logic [BSPE_CNT_W-1:0] error_count;
        logic                  result_bit;
    } t_result;

endpackage

[design/bspe_stack.sv]
// ----------------------------------------------------------------------------
// bspe_stack
// Bit stack, failure and instruction counters; executes one instruction per
// strobe and presents the program result for the instruction being executed.
// ----------------------------------------------------------------------------
module bspe_stack
    import bspe_pkg::*;
#(
    parameter int STACK_DEPTH = BSPE_STACK_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_instr  i_instr,
    output t_result o_result
);

    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SW = ((DW > BSPE_CNT_W) ? DW : BSPE_CNT_W) + 1;
    localparam logic [BSPE_CNT_W-1:0] CNT_MAX = '1;

    logic [STACK_DEPTH-1:0] r_stack, n_stack;
    logic [DW-1:0]          r_depth, n_depth;
    logic [BSPE_CNT_W-1:0]  r_fail, n_fail;
    logic [BSPE_CNT_W-1:0]  r_instr, n_instr;

    logic          fail_op;
    logic          op_bit;
    logic [IW-1:0] top_idx;
    logic [IW-1:0] sec_idx;
    logic [IW-1:0] res_idx;
    logic [SW-1:0] err_sum;

    always_comb begin
        n_stack = r_stack;
        n_depth = r_depth;
        fail_op = 1'b0;
        op_bit  = 1'b0;
        top_idx = IW'(r_depth - DW'(1));
        sec_idx = IW'(r_depth - DW'(2));
        unique case (i_instr.op)
            OP_PUSH1, OP_PUSH2, OP_PUSH3, OP_PUSH4: begin
                if (r_depth == DW'(STACK_DEPTH)) begin
                    fail_op = 1'b1;
                end else begin
                    // low two opcode bits select the variable
                    n_stack[IW'(r_depth)] = i_instr.variables[i_instr.op[1:0]];
                    n_depth = r_depth + DW'(1);
                end
            end
            OP_NOT: begin
                if (r_depth == '0) begin
                    fail_op = 1'b1;
                end else begin
                    n_stack[top_idx] = ~r_stack[top_idx];
                end
            end
            OP_AND, OP_OR, OP_XOR: begin
                if (r_depth < DW'(2)) begin
                    fail_op = 1'b1;
                end else begin
                    unique case (i_instr.op)
                        OP_AND:  op_bit = r_stack[top_idx] & r_stack[sec_idx];
                        OP_OR:   op_bit = r_stack[top_idx] | r_stack[sec_idx];
                        default: op_bit = r_stack[top_idx] ^ r_stack[sec_idx];
                    endcase
                    n_stack[top_idx] = 1'b0;
                    n_stack[sec_idx] = op_bit;
                    n_depth = r_depth - DW'(1);
                end
            end
            default: fail_op = 1'b1;
        endcase

        n_instr = (r_instr == CNT_MAX) ? r_instr : r_instr + BSPE_CNT_W'(1);
        n_fail  = (fail_op && r_fail != CNT_MAX) ? r_fail + BSPE_CNT_W'(1) : r_fail;

        res_idx = IW'(n_depth - DW'(1));
        err_sum = SW'(n_fail) + SW'(n_depth - DW'(1));
        if (n_depth == '0) begin
            o_result.result_bit  = 1'b0;
            o_result.error_count = n_instr;
        end else begin
            o_result.result_bit  = n_stack[res_idx];
            o_result.error_count = (err_sum > SW'(CNT_MAX)) ? CNT_MAX
                                                            : BSPE_CNT_W'(err_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stack <= '0;
            r_depth <= '0;
            r_fail  <= '0;
            r_instr <= '0;
        end else if (i_fire) begin
            if (i_instr.last) begin
                r_stack <= '0;
                r_depth <= '0;
                r_fail  <= '0;
                r_instr <= '0;
            end else begin
                r_stack <= n_stack;
                r_depth <= n_depth;
                r_fail  <= n_fail;
                r_instr <= n_instr;
            end
        end
    end

endmodule

[design/boolean_stack_program_evaluator_unit.sv]
// ----------------------------------------------------------------------------
// boolean_stack_program_evaluator_unit
// Stack-based boolean program evaluator: one instruction per transaction,
// one result transaction per program.
// ----------------------------------------------------------------------------
// Channel   Dir  Fields (tdata from bit 0 up)            Sideband
// s_axis    in   op[2:0], variables[6:3], pad[7]          tlast = last of program
// m_axis    out  result_bit[0], error_count[8:1], pad     -
//
// Input register, stack/counter update, output register.
// One instruction per cycle sustained while no last instruction waits; a
// program's result passes through the input and output registers to m_axis.
// An instruction marked last waits in the input register while a result is
// still held on m_axis; other instructions never wait.
// Synchronous active-low reset empties both registers and the stack.
// ----------------------------------------------------------------------------
module boolean_stack_program_evaluator_unit
    import bspe_pkg::*;
#(
    parameter int STACK_DEPTH = BSPE_STACK_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [BSPE_IN_TDATA_W-1:0]  s_axis_tdata,   // op, variables, pad
    input  logic                        s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [BSPE_OUT_TDATA_W-1:0] m_axis_tdata    // result_bit, error_count, pad
);

    logic    r_in_valid;
    t_instr  r_in;
    logic    r_out_valid;
    t_result r_out;

    logic    out_free;
    logic    proc;
    t_result core_result;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign proc          = r_in_valid && (!r_in.last || out_free);
    assign s_axis_tready = !r_in_valid || proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.op        <= t_op'(s_axis_tdata[BSPE_OP_W-1:0]);
            r_in.variables <= s_axis_tdata[BSPE_OP_W +: BSPE_VAR_W];
            r_in.last      <= s_axis_tlast;
        end
    end

    bspe_stack #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (proc),
        .i_instr (r_in),
        .o_result(core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && r_in.last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && r_in.last) begin
            r_out <= core_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(BSPE_OUT_TDATA_W - $bits(t_result))'(0), r_out};

endmodule

[design/bspe_checker.sv]
// ----------------------------------------------------------------------------
// bspe_checker
// Port-level assertions for the boolean stack program evaluator.
// ----------------------------------------------------------------------------
module bspe_checker
    import bspe_pkg::*;
(
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        s_axis_tready,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [BSPE_OUT_TDATA_W-1:0] m_axis_tdata
);

    // held result must not change while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("m_axis transaction dropped or changed under stall");

    // input side never blocks while the output side is empty
    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("s_axis stalled with empty output register");

    // no result straight out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("m_axis_tvalid high after reset");

    // a result can only follow an accepted last instruction; this checks only that reset was released before it
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(i_rst_n) && $past(i_rst_n, 2))
        else $error("result without prior program");

endmodule

bind boolean_stack_program_evaluator_unit bspe_checker u_bspe_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);
